// ===== hdl/hrs_pkg.sv =====
`timescale 1ns / 1ps

package hrs_pkg;

  // Default sizing
  localparam int NUM_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  // Width of the shared divider
  localparam int DIV_W = 64;

  // Item opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_RANGE_LOW = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
  localparam logic [1:0] REG_BINS_USED = 2'd2;

  // Divider operand selects
  localparam logic [1:0] DIV_BIN  = 2'd0;
  localparam logic [1:0] DIV_MEAN = 2'd1;
  localparam logic [1:0] DIV_VAR  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       clr_start;
    logic       sweep;
    logic       div_start;
    logic [1:0] div_sel;
    logic       read_rd;
    logic       bin_apply;
    logic       bin_write;
    logic       first_load;
    logic       mul;
    logic       acc;
    logic       var_load;
    logic       out_load;
  } hrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       div_done;
    logic       sweep_last;
    logic       first;
    logic       out_busy;
    logic [1:0] opcode;
  } hrs_sts_t;

endpackage

// ===== hdl/hrs_in_if.sv =====
`timescale 1ns / 1ps

interface hrs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] sample;
  logic [9:0]         bin_index;

  modport source (output valid, opcode, sample, bin_index, input ready);
  modport sink   (input valid, opcode, sample, bin_index, output ready);
endinterface

// ===== hdl/hrs_out_if.sv =====
`timescale 1ns / 1ps

interface hrs_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        bin_count;
  logic [31:0]        total_count;
  logic [31:0]        below_count;
  logic [31:0]        above_count;
  logic signed [31:0] max_seen;
  logic signed [31:0] min_seen;
  logic signed [31:0] mean_value;
  logic [62:0]        variance_value;
  logic signed [31:0] last_sample;

  modport source (output valid, bin_count, total_count, below_count, above_count,
                  max_seen, min_seen, mean_value, variance_value, last_sample,
                  input ready);
  modport sink   (input valid, bin_count, total_count, below_count, above_count,
                  max_seen, min_seen, mean_value, variance_value, last_sample,
                  output ready);
endinterface

// ===== hdl/hrs_ram.sv =====
`timescale 1ns / 1ps

module hrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/hrs_div.sv =====
`timescale 1ns / 1ps

module hrs_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W) + 1;

  logic [W:0]    rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    rem_next;
  logic [W-1:0]  quo_next;

  // One restoring step per cycle
  always_comb begin
    shifted = {rem[W-1:0], quo[W-1]};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = shifted - {1'b0, dvs};
      quo_next = {quo[W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      quo_next = {quo[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== hdl/hrs_ctrl.sv =====
`timescale 1ns / 1ps

module hrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrs_pkg::hrs_sts_t sts,
  output hrs_pkg::hrs_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_SWEEP  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_LAUNCH = 12'b000000000100,
    S_BDIV   = 12'b000000001000,
    S_BWRITE = 12'b000000010000,
    S_MDIV   = 12'b000000100000,
    S_ACC    = 12'b000001000000,
    S_VSTART = 12'b000010000000,
    S_VDIV   = 12'b000100000000,
    S_DONE   = 12'b001000000000,
    S_MUL    = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   reply, reply_next;

  assign in_ready = (state == S_IDLE);

  // Sequencing of one item
  always_comb begin
    cmd        = '0;
    state_next = state;
    reply_next = reply;
    case (state)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        case (sts.opcode)
          hrs_pkg::OP_PUT: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = hrs_pkg::DIV_BIN;
            state_next    = S_BDIV;
          end
          hrs_pkg::OP_READ: begin
            cmd.read_rd = 1'b1;
            state_next  = S_DONE;
          end
          hrs_pkg::OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            reply_next    = 1'b1;
            state_next    = S_SWEEP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_BDIV: begin
        if (sts.div_done) begin
          cmd.bin_apply = 1'b1;
          state_next    = S_BWRITE;
        end
      end
      S_BWRITE: begin
        cmd.bin_write = 1'b1;
        if (sts.first) begin
          cmd.first_load = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = hrs_pkg::DIV_MEAN;
          state_next    = S_MDIV;
        end
      end
      S_MDIV: begin
        if (sts.div_done) begin
          cmd.mul    = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_VSTART;
      end
      S_VSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = hrs_pkg::DIV_VAR;
        state_next    = S_VDIV;
      end
      S_VDIV: begin
        if (sts.div_done) begin
          cmd.var_load = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          reply_next   = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

endmodule

// ===== hdl/hrs_datapath.sv =====
`timescale 1ns / 1ps

module hrs_datapath #(
  parameter int NUM_BINS    = hrs_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = hrs_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  hrs_pkg::hrs_cmd_t  cmd,
  output hrs_pkg::hrs_sts_t  sts,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_sample,
  input  logic [9:0]         in_bin_index,
  input  logic signed [31:0] range_low,
  input  logic [30:0]        bin_width,
  input  logic [10:0]        bins_used,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        bin_count,
  output logic [31:0]        total_count,
  output logic [31:0]        below_count,
  output logic [31:0]        above_count,
  output logic signed [31:0] max_seen,
  output logic signed [31:0] min_seen,
  output logic signed [31:0] mean_value,
  output logic [62:0]        variance_value,
  output logic signed [31:0] last_sample
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int DW = hrs_pkg::DIV_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Captured item
  logic [1:0]         op_r;
  logic signed [31:0] sample_r;
  logic [9:0]         bin_index_r;

  // Statistics
  logic [COUNT_WIDTH-1:0] total, under, over;
  logic signed [31:0]     run_max, run_min, mean, last;
  logic [63:0]            sdsum;
  logic [62:0]            var_r;
  logic [63:0]            prod_r;

  // Bin store access
  logic [AW-1:0]          sweep_addr;
  logic [AW-1:0]          addr_r;
  logic                   hit_r, rhit_r;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  // Divider
  logic          div_busy, div_done;
  logic [DW-1:0] div_q, dvd, dvs;

  // Combinational helpers
  logic [30:0]        w_eff;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [34:0]        bin_dvd;
  logic [63:0]        used;
  logic               under_c, over_c;
  logic signed [32:0] d1, d2;
  logic [32:0]        d1_mag, d2_mag;
  logic [31:0]        step;
  logic signed [31:0] mnew;
  logic [64:0]        acc_sum;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // Bin index: round((v - low) / w), halves away from zero
  assign w_eff    = (bin_width == '0) ? 31'd1 : bin_width;
  assign diff     = 33'(sample_r) - 33'(range_low);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign bin_dvd  = 35'({diff_mag, 1'b0}) + 35'(w_eff);
  assign used     = (64'(bins_used) > 64'(NUM_BINS)) ? 64'(NUM_BINS) : 64'(bins_used);
  assign under_c  = diff[32] && (div_q != '0);
  assign over_c   = !under_c && (div_q >= used);

  // Welford terms
  assign d1     = 33'(sample_r) - 33'(mean);
  assign d1_mag = d1[32] ? 33'(-d1) : 33'(d1);
  assign step   = div_q[31:0];
  assign mnew   = d1[32] ? (mean - $signed(step)) : (mean + $signed(step));
  assign d2     = 33'(sample_r) - 33'(mnew);
  assign d2_mag = d2[32] ? 33'(-d2) : 33'(d2);
  assign acc_sum = {1'b0, sdsum} + 65'(prod_r >> 16);

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      hrs_pkg::DIV_BIN: begin
        dvd = DW'(bin_dvd);
        dvs = DW'({w_eff, 1'b0});
      end
      hrs_pkg::DIV_MEAN: begin
        dvd = DW'(d1_mag);
        dvs = DW'(total);
      end
      default: begin
        dvd = DW'(sdsum);
        dvs = DW'(total) - DW'(1);
      end
    endcase
  end

  hrs_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Bin store ports
  assign ram_re    = cmd.read_rd | cmd.bin_apply;
  assign ram_raddr = cmd.read_rd ? AW'(bin_index_r) : div_q[AW-1:0];
  assign ram_we    = cmd.sweep | (cmd.bin_write & hit_r);
  assign ram_waddr = cmd.sweep ? sweep_addr : addr_r;
  assign ram_wdata = cmd.sweep ? '0 : sat_inc(ram_rdata);

  hrs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Item capture and bin bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_opcode;
      sample_r    <= in_sample;
      bin_index_r <= in_bin_index;
    end
    if (cmd.bin_apply) begin
      hit_r  <= !under_c && !over_c;
      addr_r <= div_q[AW-1:0];
    end
    if (cmd.read_rd) begin
      rhit_r <= (32'(bin_index_r) < 32'(NUM_BINS));
    end
    if (cmd.mul) begin
      prod_r <= d1_mag[31:0] * d2_mag[31:0];
    end
  end

  // Statistics registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      sweep_addr <= '0;
      total      <= '0;
      under      <= '0;
      over       <= '0;
      run_max    <= 32'sh80000000;
      run_min    <= 32'sh7FFFFFFF;
      mean       <= '0;
      sdsum      <= '0;
      var_r      <= '0;
      last       <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
      if (cmd.bin_apply) begin
        last  <= sample_r;
        total <= sat_inc(total);
        if (sample_r > run_max) run_max <= sample_r;
        if (sample_r < run_min) run_min <= sample_r;
        if (under_c) under <= sat_inc(under);
        if (over_c)  over  <= sat_inc(over);
      end
      if (cmd.first_load) begin
        mean  <= sample_r;
        sdsum <= '0;
        var_r <= '0;
      end
      if (cmd.mul) begin
        mean <= mnew;
      end
      if (cmd.acc) begin
        sdsum <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
      end
      if (cmd.var_load) begin
        var_r <= div_q[63] ? {63{1'b1}} : div_q[62:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_count      <= (op_r == hrs_pkg::OP_READ && rhit_r) ? 32'(ram_rdata) : 32'd0;
      total_count    <= 32'(total);
      below_count    <= 32'(under);
      above_count    <= 32'(over);
      max_seen       <= run_max;
      min_seen       <= run_min;
      mean_value     <= (total != '0) ? mean : 32'sd0;
      variance_value <= var_r;
      last_sample    <= last;
    end
  end

  assign sts.div_done   = div_done;
  assign sts.sweep_last = (sweep_addr == AW'(NUM_BINS - 1));
  assign sts.first      = (total == COUNT_WIDTH'(1));
  assign sts.out_busy   = out_valid && !out_ready;
  assign sts.opcode     = op_r;

`ifndef NO_ASSERTIONS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");
  a_var_zero: assert property (@(posedge clk) disable iff (rst)
    (total < COUNT_WIDTH'(2)) |-> (var_r == '0))
    else $error("variance nonzero below two samples");
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (total != '0) |-> (run_min <= run_max))
    else $error("minimum above maximum");
`endif

endmodule

// ===== hdl/histogram_running_stats_core.sv =====
`timescale 1ns / 1ps
// Put: three serial 64-step divisions (bin index, mean step, variance) per item;
//   the first sample after a clear needs the bin index division only.
// Read bin and no-op: no division. Clear: a sweep zeroes the whole bin store.
// One item at a time; the next item is taken while a result waits to be read.
// Reset (synchronous): statistics clear at once, then a sweep zeroes the bin store
//   before the first item is accepted.

module histogram_running_stats_core #(
  parameter int NUM_BINS    = hrs_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH = hrs_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hrs_in_if.sink      req,
  hrs_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic signed [31:0] range_low;
  logic [30:0]        bin_width;
  logic [10:0]        bins_used;
  logic               cfg_wr;
  hrs_pkg::hrs_cmd_t  cmd;
  hrs_pkg::hrs_sts_t  sts;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low <= '0;
      bin_width <= 31'd65536;
      bins_used <= 11'd1024;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        hrs_pkg::REG_RANGE_LOW: range_low <= pwdata;
        hrs_pkg::REG_BIN_WIDTH: bin_width <= pwdata[30:0];
        hrs_pkg::REG_BINS_USED: bins_used <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hrs_pkg::REG_RANGE_LOW: prdata = range_low;
      hrs_pkg::REG_BIN_WIDTH: prdata = 32'(bin_width);
      hrs_pkg::REG_BINS_USED: prdata = 32'(bins_used);
      default:                prdata = '0;
    endcase
  end

  hrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrs_datapath #(.NUM_BINS(NUM_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (req.opcode),
    .in_sample      (req.sample),
    .in_bin_index   (req.bin_index),
    .range_low      (range_low),
    .bin_width      (bin_width),
    .bins_used      (bins_used),
    .out_ready      (rsp.ready),
    .out_valid      (rsp.valid),
    .bin_count      (rsp.bin_count),
    .total_count    (rsp.total_count),
    .below_count    (rsp.below_count),
    .above_count    (rsp.above_count),
    .max_seen       (rsp.max_seen),
    .min_seen       (rsp.min_seen),
    .mean_value     (rsp.mean_value),
    .variance_value (rsp.variance_value),
    .last_sample    (rsp.last_sample)
  );

endmodule

// ===== tb/histogram_running_stats_core_test.sv =====
`timescale 1ns / 1ps

module histogram_running_stats_core_test;

  // One result item as the block reports it
  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] total_count;
    logic [31:0] below_count;
    logic [31:0] above_count;
    logic [31:0] max_seen;
    logic [31:0] min_seen;
    logic [31:0] mean_value;
    logic [62:0] variance_value;
    logic [31:0] last_sample;
  } stats_rsp_t;

  // Histogram and Welford statistics predictor plus expected-result store
  class stats_board;
    bit signed [31:0] low_edge;
    bit [30:0]        width_q;
    bit [10:0]        used_bins;
    longint unsigned  bin_cnt[1024];
    longint unsigned  n_total, n_under, n_over, dev_sum;
    longint           v_max, v_min, avg, last_v;
    stats_rsp_t       pending_q[$];
    int               errors;

    function new();
      low_edge = 0;
      width_q = 31'd65536;
      used_bins = 11'd1024;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (bin_cnt[k]) bin_cnt[k] = 0;
      n_total = 0;
      n_under = 0;
      n_over = 0;
      dev_sum = 0;
      v_max = -64'sd2147483648;
      v_min = 64'sd2147483647;
      avg = 0;
      last_v = 0;
    endfunction

    function longint unsigned bump(longint unsigned c);
      return (c >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : c + 1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        hrs_pkg::REG_RANGE_LOW: low_edge = val;
        hrs_pkg::REG_BIN_WIDTH: width_q = val[30:0];
        hrs_pkg::REG_BINS_USED: used_bins = val[10:0];
        default: ;
      endcase
    endfunction

    function void add_sample(longint v);
      longint unsigned w, u, m, q, ad1, ad2, stp, term;
      longint diff, bin, d1, d2, mnew;
      w = (width_q == 0) ? 1 : width_q;
      u = (used_bins > 1024) ? 1024 : used_bins;
      diff = v - longint'(low_edge);
      m = (diff < 0) ? -diff : diff;
      q = (2 * m + w) / (2 * w);
      bin = (diff < 0) ? -longint'(q) : longint'(q);
      last_v = v;
      if (v > v_max) v_max = v;
      if (v < v_min) v_min = v;
      if (bin >= 0 && $unsigned(bin) >= u) n_over = bump(n_over);
      else if (bin < 0) n_under = bump(n_under);
      else bin_cnt[bin] = bump(bin_cnt[bin]);
      n_total = bump(n_total);
      if (n_total == 1) begin
        avg = v;
        dev_sum = 0;
      end else begin
        d1 = v - avg;
        ad1 = (d1 < 0) ? -d1 : d1;
        stp = ad1 / n_total;
        mnew = (d1 < 0) ? avg - longint'(stp) : avg + longint'(stp);
        d2 = v - mnew;
        ad2 = (d2 < 0) ? -d2 : d2;
        term = (ad1 * ad2) >> 16;
        avg = mnew;
        dev_sum = (dev_sum > ~64'd0 - term) ? ~64'd0 : dev_sum + term;
      end
    endfunction

    // Accepted input item: update the model, queue the expected result
    function void note_item(logic [1:0] op, logic signed [31:0] smp, logic [9:0] idx);
      stats_rsp_t e;
      longint unsigned var_q;
      longint unsigned bc;
      bc = 0;
      var_q = 0;
      case (op)
        hrs_pkg::OP_PUT:   add_sample(longint'(smp));
        hrs_pkg::OP_READ:  bc = bin_cnt[idx];
        hrs_pkg::OP_CLEAR: wipe();
        default: ;
      endcase
      if (n_total > 1) begin
        var_q = dev_sum / (n_total - 1);
        if (var_q > 64'h7FFF_FFFF_FFFF_FFFF) var_q = 64'h7FFF_FFFF_FFFF_FFFF;
      end
      e.bin_count = bc[31:0];
      e.total_count = n_total[31:0];
      e.below_count = n_under[31:0];
      e.above_count = n_over[31:0];
      e.max_seen = v_max[31:0];
      e.min_seen = v_min[31:0];
      e.mean_value = (n_total > 0) ? avg[31:0] : 32'd0;
      e.variance_value = var_q[62:0];
      e.last_sample = last_v[31:0];
      pending_q.push_back(e);
    endfunction

    function void field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    // Accepted result item: compare with the oldest expectation
    function void check_result(stats_rsp_t a);
      stats_rsp_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      field("bin_count", e.bin_count, a.bin_count);
      field("total_count", e.total_count, a.total_count);
      field("below_count", e.below_count, a.below_count);
      field("above_count", e.above_count, a.above_count);
      field("max_seen", e.max_seen, a.max_seen);
      field("min_seen", e.min_seen, a.min_seen);
      field("mean_value", e.mean_value, a.mean_value);
      field("variance_value", e.variance_value, a.variance_value);
      field("last_sample", e.last_sample, a.last_sample);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  hrs_in_if  req ();
  hrs_out_if rsp ();

  histogram_running_stats_core DUT (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stats_board board = new();
  int  send_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  bit  hold_req = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_req) begin
      hold_left <= 400;
      rsp.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watch both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        board.note_item(req.opcode, req.sample, req.bin_index);
      if (rsp.valid && rsp.ready)
        board.check_result('{rsp.bin_count, rsp.total_count, rsp.below_count,
                             rsp.above_count, rsp.max_seen, rsp.min_seen,
                             rsp.mean_value, rsp.variance_value, rsp.last_sample});
    end
  end

  // Offer one item and hold it until accepted
  task send_item(logic [1:0] op, logic [31:0] smp, logic [9:0] idx);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid <= 1;
    req.opcode <= op;
    req.sample <= smp;
    req.bin_index <= idx;
    do @(posedge clk); while (!req.ready);
  endtask

  task drain();
    req.valid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_reg(idx, val);
  endtask

  task configure(logic [31:0] lo, logic [31:0] w, logic [31:0] u);
    drain();
    write_reg(hrs_pkg::REG_RANGE_LOW, lo);
    write_reg(hrs_pkg::REG_BIN_WIDTH, w);
    write_reg(hrs_pkg::REG_BINS_USED, u);
  endtask

  // One random item, mostly samples aimed at bins in use
  task random_item();
    longint w, u, k, s;
    int     pick;
    w = (board.width_q == 0) ? 1 : board.width_q;
    u = (board.used_bins > 1024) ? 1024 : board.used_bins;
    pick = $urandom_range(99);
    if (pick < 50) begin
      k = longint'($urandom_range(u + 6)) - 3;
      s = longint'(board.low_edge) + k * w + longint'($urandom_range(w)) - w / 2;
      send_item(hrs_pkg::OP_PUT, s[31:0], 10'd0);
    end else if (pick < 68) begin
      send_item(hrs_pkg::OP_PUT, $urandom, 10'd0);
    end else if (pick < 88) begin
      if ($urandom_range(1) && u > 0)
        send_item(hrs_pkg::OP_READ, $urandom, 10'($urandom_range(u - 1)));
      else
        send_item(hrs_pkg::OP_READ, $urandom, 10'($urandom_range(1023)));
    end else if (pick < 93) begin
      send_item(hrs_pkg::OP_NOP, $urandom, 10'($urandom));
    end else begin
      send_item(hrs_pkg::OP_CLEAR, $urandom, 10'($urandom));
    end
  endtask

  initial begin
    logic [31:0] lo_v[6];
    logic [31:0] w_v[6];
    logic [31:0] u_v[6];
    req.valid <= 0;
    req.opcode <= hrs_pkg::OP_NOP;
    req.sample <= 0;
    req.bin_index <= 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: default registers, edges of rounding and range
    send_item(hrs_pkg::OP_PUT, 32'h0000_0000, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'h0000_8000, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'h0000_7FFF, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'hFFFF_8000, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'hFFFF_8001, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'h7FFF_FFFF, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'h8000_0000, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'd1023 << 16, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'd1024 << 16, 10'd0);
    send_item(hrs_pkg::OP_READ, 0, 10'd0);
    send_item(hrs_pkg::OP_READ, 0, 10'd1);
    send_item(hrs_pkg::OP_READ, 0, 10'd1023);
    send_item(hrs_pkg::OP_READ, 0, 10'd512);
    send_item(hrs_pkg::OP_NOP, 32'hFFFF_FFFF, 10'h3FF);
    send_item(hrs_pkg::OP_CLEAR, 0, 10'd0);
    send_item(hrs_pkg::OP_READ, 0, 10'd1);
    send_item(hrs_pkg::OP_PUT, 32'd5 << 16, 10'd0);
    send_item(hrs_pkg::OP_PUT, 32'd5 << 16, 10'd0);
    send_item(hrs_pkg::OP_READ, 0, 10'd5);

    // Register settings: extremes, zero width, no bins, too many bins
    lo_v = '{32'h8000_0000, 32'h7FFF_FFFF, $urandom, 32'hFFFB_0000, $urandom, 32'h0};
    w_v  = '{32'd1, 32'h7FFF_FFFF, 32'd0, 32'h0000_8000, $urandom_range(16, 1 << 20),
             32'd65536};
    u_v  = '{32'd5, 32'd0, 32'd2047, 32'd20, $urandom_range(1, 64), 32'd1024};

    for (int p = 0; p < 6; p++) begin
      configure(lo_v[p], w_v[p], u_v[p]);
      case (p % 4)
        0: begin send_pct = 0; stall_pct = 0; end
        1: begin send_pct = 48; stall_pct = 0; end
        2: begin send_pct = 0; stall_pct = 48; end
        default: begin send_pct = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < 108; n++) begin
        if (p == 1 && n == 20) begin
          // Long receiver hold-off while items keep coming
          hold_req <= 1;
          @(posedge clk);
          hold_req <= 0;
        end
        if (p == 3 && n == 50) drain();
        random_item();
      end
    end

    req.valid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
